[rtl/core/gtf_pkg.sv]
// gtf_pkg: shared types, widths and codes for the grouped team queue
// used by the interfaces, the controller, the datapath and the top level
// no dependencies
package gtf_pkg;

    // fixed field widths of the channels
    localparam int ELEM_W    = 20;
    localparam int TEAM_ID_W = 10;
    localparam int STATUS_W  = 2;

    // default sizing
    localparam int DEF_MAX_TEAMS    = 1024;
    localparam int DEF_SLOT_COUNT   = 1024;
    localparam int DEF_ELEMENT_BITS = 20;

    // request codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic accept;
        logic enq_wr;
        logic deq_grp;
        logic deq_slot;
        logic deq_wr;
        logic err_wr;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic bad_req;
        logic is_deq;
        logic out_free;
    } sts_t;

endpackage

[rtl/core/gtf_if.sv]
// gtf_if: request and response channel interfaces with valid/ready handshake
// depends on gtf_pkg for the payload widths
interface gtf_in_if;
    import gtf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [ELEM_W-1:0]    element_id;
    logic [TEAM_ID_W-1:0] team_id;

    modport source (output valid, output action, output element_id, output team_id,
                    input ready);
    modport sink   (input valid, input action, input element_id, input team_id,
                    output ready);
endinterface

interface gtf_out_if;
    import gtf_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ELEM_W-1:0]   out_element;

    modport source (output valid, output status, output out_element, input ready);
    modport sink   (input valid, input status, input out_element, output ready);
endinterface

[rtl/core/gtf_ctrl.sv]
// gtf_ctrl: sequencing state machine of the grouped team queue
// depends on gtf_pkg for the command and status structs
module gtf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  gtf_pkg::sts_t sts,
    output logic          in_ready,
    output gtf_pkg::cmd_t cmd
);
    import gtf_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_ENQ_WR   = 7'b0000100,
        S_DEQ_GRP  = 7'b0001000,
        S_DEQ_SLOT = 7'b0010000,
        S_DEQ_WR   = 7'b0100000,
        S_ERR      = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.bad_req)
                    begin
                        state_next = S_ERR;
                    end
                    else if (sts.is_deq)
                    begin
                        state_next = S_DEQ_GRP;
                    end
                    else
                    begin
                        state_next = S_ENQ_WR;
                    end
                end
            end
            S_ENQ_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.enq_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DEQ_GRP:
            begin
                cmd.deq_grp = 1'b1;
                state_next  = S_DEQ_SLOT;
            end
            S_DEQ_SLOT:
            begin
                cmd.deq_slot = 1'b1;
                state_next   = S_DEQ_WR;
            end
            S_DEQ_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.deq_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.err_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/gtf_dp.sv]
// gtf_dp: memories, pointers and result register of the grouped team queue
// depends on gtf_pkg; driven by commands from gtf_ctrl
module gtf_dp #(
    parameter int MAX_TEAMS    = gtf_pkg::DEF_MAX_TEAMS,
    parameter int SLOT_COUNT   = gtf_pkg::DEF_SLOT_COUNT,
    parameter int ELEMENT_BITS = gtf_pkg::DEF_ELEMENT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gtf_pkg::cmd_t                   cmd,
    output gtf_pkg::sts_t                   sts,
    input  logic                            action,
    input  logic [gtf_pkg::ELEM_W-1:0]      element_id,
    input  logic [gtf_pkg::TEAM_ID_W-1:0]   team_id,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [gtf_pkg::STATUS_W-1:0]    status,
    output logic [gtf_pkg::ELEM_W-1:0]      out_element
);
    import gtf_pkg::*;

    localparam int TB    = $clog2(MAX_TEAMS);
    localparam int SB    = $clog2(SLOT_COUNT);
    localparam int UW    = $clog2(SLOT_COUNT + 1);
    localparam int EW    = (ELEMENT_BITS < ELEM_W) ? ELEMENT_BITS : ELEM_W;
    localparam int CLR_N = (MAX_TEAMS > SLOT_COUNT) ? MAX_TEAMS : SLOT_COUNT;
    localparam int CW    = $clog2(CLR_N);
    localparam longint ID_MAX = (64'd1 << TEAM_ID_W) - 1;

    // memories
    logic [TB-1:0] order_ring   [MAX_TEAMS];
    logic [SB-1:0] group_head   [MAX_TEAMS];
    logic [SB-1:0] group_tail   [MAX_TEAMS];
    logic          group_active [MAX_TEAMS];
    logic [EW-1:0] slot_element [SLOT_COUNT];
    logic [SB-1:0] slot_next    [SLOT_COUNT];
    logic [SB-1:0] free_ring    [SLOT_COUNT];

    // registered read data
    logic [TB-1:0] order_rd;
    logic [SB-1:0] head_rd;
    logic [SB-1:0] tail_rd;
    logic          active_rd;
    logic [EW-1:0] elem_rd;
    logic [SB-1:0] next_rd;
    logic [SB-1:0] free_rd;

    // control registers
    logic [CW-1:0] clr_cnt_reg,    clr_cnt_next;
    logic [TB-1:0] order_head_reg, order_head_next;
    logic [TB-1:0] order_tail_reg, order_tail_next;
    logic [SB-1:0] free_head_reg,  free_head_next;
    logic [SB-1:0] free_tail_reg,  free_tail_next;
    logic [UW-1:0] used_reg,       used_next;
    logic          out_valid_reg,  out_valid_next;

    // payload registers
    logic [TB-1:0]       team_reg;
    logic [EW-1:0]       elem_reg;
    logic [SB-1:0]       slot_reg;
    logic                last_reg;
    status_t             err_code_reg;
    status_t             status_reg;
    logic [ELEM_W-1:0]   out_elem_reg;

    logic [TEAM_ID_W-1:0] rem;
    logic [TB-1:0]        team_in;
    logic                 clr_team;
    logic                 clr_slot;
    logic                 full;
    logic                 empty;

    // team id reduced modulo the team count by shifted subtraction
    always_comb
    begin
        rem = team_id;
        for (int i = TEAM_ID_W - 1; i >= 0; i--)
        begin
            if ((longint'(MAX_TEAMS) << i) <= ID_MAX)
            begin
                if (longint'(rem) >= (longint'(MAX_TEAMS) << i))
                begin
                    rem = rem - TEAM_ID_W'(longint'(MAX_TEAMS) << i);
                end
            end
        end
        team_in = TB'(rem);
    end

    // status toward the controller
    assign clr_team = ({1'b0, clr_cnt_reg} < (CW + 1)'(MAX_TEAMS));
    assign clr_slot = ({1'b0, clr_cnt_reg} < (CW + 1)'(SLOT_COUNT));
    assign full     = (used_reg == UW'(SLOT_COUNT));
    assign empty    = (used_reg == '0);

    always_comb
    begin
        sts.clear_done = (clr_cnt_reg == CW'(CLR_N - 1));
        sts.is_deq     = (action == ACT_DEQ);
        sts.bad_req    = (action == ACT_DEQ) ? empty : full;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // team order ring
    always_ff @(posedge clk)
    begin
        if (cmd.enq_wr && !active_rd)
        begin
            order_ring[order_tail_reg] <= team_reg;
        end
        if (cmd.accept)
        begin
            order_rd <= order_ring[order_head_reg];
        end
    end

    // group head pointers
    always_ff @(posedge clk)
    begin
        if (cmd.enq_wr && !active_rd)
        begin
            group_head[team_reg] <= free_rd;
        end
        else if (cmd.deq_wr && !last_reg)
        begin
            group_head[team_reg] <= next_rd;
        end
        if (cmd.deq_grp)
        begin
            head_rd <= group_head[order_rd];
        end
    end

    // group tail pointers
    always_ff @(posedge clk)
    begin
        if (cmd.enq_wr)
        begin
            group_tail[team_reg] <= free_rd;
        end
        if (cmd.accept)
        begin
            tail_rd <= group_tail[team_in];
        end
        else if (cmd.deq_grp)
        begin
            tail_rd <= group_tail[order_rd];
        end
    end

    // group active flags, swept to zero after reset
    always_ff @(posedge clk)
    begin
        if (cmd.clear && clr_team)
        begin
            group_active[clr_cnt_reg[TB-1:0]] <= 1'b0;
        end
        else if (cmd.enq_wr && !active_rd)
        begin
            group_active[team_reg] <= 1'b1;
        end
        else if (cmd.deq_wr && last_reg)
        begin
            group_active[team_reg] <= 1'b0;
        end
        if (cmd.accept)
        begin
            active_rd <= group_active[team_in];
        end
    end

    // slot element store
    always_ff @(posedge clk)
    begin
        if (cmd.enq_wr)
        begin
            slot_element[free_rd] <= elem_reg;
        end
        if (cmd.deq_slot)
        begin
            elem_rd <= slot_element[head_rd];
        end
    end

    // slot links
    always_ff @(posedge clk)
    begin
        if (cmd.enq_wr && active_rd)
        begin
            slot_next[tail_rd] <= free_rd;
        end
        if (cmd.deq_slot)
        begin
            next_rd <= slot_next[head_rd];
        end
    end

    // free slot ring, filled with every slot index after reset
    always_ff @(posedge clk)
    begin
        if (cmd.clear && clr_slot)
        begin
            free_ring[clr_cnt_reg[SB-1:0]] <= clr_cnt_reg[SB-1:0];
        end
        else if (cmd.deq_wr)
        begin
            free_ring[free_tail_reg] <= slot_reg;
        end
        if (cmd.accept)
        begin
            free_rd <= free_ring[free_head_reg];
        end
    end

    // pointer and count updates
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        order_head_next = order_head_reg;
        order_tail_next = order_tail_reg;
        free_head_next  = free_head_reg;
        free_tail_next  = free_tail_reg;
        used_next       = used_reg;
        if (cmd.clear)
        begin
            clr_cnt_next = clr_cnt_reg + CW'(1);
        end
        if (cmd.enq_wr)
        begin
            free_head_next = (free_head_reg == SB'(SLOT_COUNT - 1)) ? '0
                                                                    : free_head_reg + SB'(1);
            used_next = used_reg + UW'(1);
            if (!active_rd)
            begin
                order_tail_next = (order_tail_reg == TB'(MAX_TEAMS - 1)) ? '0
                                                                         : order_tail_reg + TB'(1);
            end
        end
        if (cmd.deq_wr)
        begin
            free_tail_next = (free_tail_reg == SB'(SLOT_COUNT - 1)) ? '0
                                                                    : free_tail_reg + SB'(1);
            used_next = used_reg - UW'(1);
            if (last_reg)
            begin
                order_head_next = (order_head_reg == TB'(MAX_TEAMS - 1)) ? '0
                                                                         : order_head_reg + TB'(1);
            end
        end
    end

    // result handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.enq_wr || cmd.deq_wr || cmd.err_wr)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            order_head_reg <= '0;
            order_tail_reg <= '0;
            free_head_reg  <= '0;
            free_tail_reg  <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_cnt_reg    <= clr_cnt_next;
            order_head_reg <= order_head_next;
            order_tail_reg <= order_tail_next;
            free_head_reg  <= free_head_next;
            free_tail_reg  <= free_tail_next;
            used_reg       <= used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            team_reg     <= team_in;
            elem_reg     <= element_id[EW-1:0];
            err_code_reg <= (action == ACT_DEQ) ? ST_EMPTY : ST_FULL;
        end
        else if (cmd.deq_grp)
        begin
            team_reg <= order_rd;
        end
        if (cmd.deq_slot)
        begin
            slot_reg <= head_rd;
            last_reg <= (head_rd == tail_rd);
        end
        if (cmd.enq_wr)
        begin
            status_reg   <= ST_ENQ;
            out_elem_reg <= '0;
        end
        else if (cmd.deq_wr)
        begin
            status_reg   <= ST_DEQ;
            out_elem_reg <= ELEM_W'(elem_rd);
        end
        else if (cmd.err_wr)
        begin
            status_reg   <= err_code_reg;
            out_elem_reg <= '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_element = out_elem_reg;

endmodule

[rtl/core/grouped_team_fifo.sv]
// grouped_team_fifo: team queue; one request at a time: an enqueue goes from
// accept to the result write, a dequeue through the group and slot reads to the
// result write, a refused request to the error result, each result waiting for a
// free output register; the steps are the registered memory reads (order ring,
// group head/tail, slot store); after reset a clearing pass fills the free ring
// and clears the group flags; no request is taken until it ends
module grouped_team_fifo #(
    parameter int MAX_TEAMS    = gtf_pkg::DEF_MAX_TEAMS,
    parameter int SLOT_COUNT   = gtf_pkg::DEF_SLOT_COUNT,
    parameter int ELEMENT_BITS = gtf_pkg::DEF_ELEMENT_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    gtf_in_if.sink    req,
    gtf_out_if.source rsp
);
    import gtf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    gtf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .sts      (sts),
        .in_ready (req.ready),
        .cmd      (cmd)
    );

    // storage and result register
    gtf_dp #(
        .MAX_TEAMS    (MAX_TEAMS),
        .SLOT_COUNT   (SLOT_COUNT),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .action      (req.action),
        .element_id  (req.element_id),
        .team_id     (req.team_id),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .status      (rsp.status),
        .out_element (rsp.out_element)
    );

`ifndef SYNTHESIS
    // no request taken during the clearing pass
    a_no_ready_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !req.ready)
        else $error("request ready during clearing pass");

    // at most one result produced per cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.enq_wr, cmd.deq_wr, cmd.err_wr}))
        else $error("more than one result in a cycle");

    // a result is only produced into a free output register
    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.enq_wr || cmd.deq_wr || cmd.err_wr) |-> sts.out_free)
        else $error("result overwrites a pending beat");

    // one request at a time: ready drops after an accepted beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !req.ready)
        else $error("ready held after accept");
`endif

endmodule
